// ===== src/f2iq_pkg.sv =====
package f2iq_pkg;

    localparam int unsigned C_NUM_CHAN = 4;
    localparam int unsigned C_LATENCY  = 6;

    localparam logic [63:0]        C_CHAN_RESET  = 64'h3F80_0000_0000_0000;
    localparam logic signed [7:0]  C_CLAMP_MIN_RESET = -8'sd128;
    localparam logic signed [7:0]  C_CLAMP_MAX_RESET = 8'sd127;
    localparam logic [31:0]        C_QNAN        = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        REG_CHAN0,
        REG_CHAN1,
        REG_CHAN2,
        REG_CHAN3,
        REG_CLAMP_MIN,
        REG_CLAMP_MAX
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] sample0;
        logic [31:0] sample1;
        logic [31:0] sample2;
        logic [31:0] sample3;
        logic        last_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] code0;
        logic signed [7:0] code1;
        logic signed [7:0] code2;
        logic signed [7:0] code3;
        logic              last_out;
    } t_out_beat;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       hit;
        n   = 6'd48;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (v[i] && !hit) begin
                n   = 6'(47 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== src/f2iq_fmul.sv =====
module f2iq_fmul
    import f2iq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);

    logic [7:0]  ea_raw, eb_raw, ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic [47:0]        r1_prod;
    logic signed [10:0] r1_exp;
    logic               r1_sign, r1_nan, r1_inf;

    logic [5:0]         n2_lz;
    logic [47:0]        r2_prod;
    logic [5:0]         r2_lz;
    logic signed [10:0] r2_exp;
    logic               r2_sign, r2_nan, r2_inf, r2_zero;

    logic signed [10:0] s3_shl;
    logic [10:0]        s3_rsh;
    logic [47:0]        s3_pn;
    logic               s3_st, s3_g;
    logic [23:0]        s3_mant;
    logic [7:0]         s3_eenc;
    logic [31:0]        s3_rnd;
    logic [31:0]        n_p;
    logic [31:0]        r_p;

    assign ea_raw = i_a[30:23];
    assign eb_raw = i_b[30:23];
    assign ma     = {|ea_raw, i_a[22:0]};
    assign mb     = {|eb_raw, i_b[22:0]};
    assign ea     = (ea_raw == 8'd0) ? 8'd1 : ea_raw;
    assign eb     = (eb_raw == 8'd0) ? 8'd1 : eb_raw;
    assign a_nan  = (ea_raw == 8'hFF) && (i_a[22:0] != 23'd0);
    assign b_nan  = (eb_raw == 8'hFF) && (i_b[22:0] != 23'd0);
    assign a_inf  = (ea_raw == 8'hFF) && (i_a[22:0] == 23'd0);
    assign b_inf  = (eb_raw == 8'hFF) && (i_b[22:0] == 23'd0);
    assign a_zero = (i_a[30:0] == 31'd0);
    assign b_zero = (i_b[30:0] == 31'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= ma * mb;
            r1_exp  <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
            r1_sign <= i_a[31] ^ i_b[31];
            r1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            r1_inf  <= a_inf | b_inf;
        end
    end

    assign n2_lz = lzc48(r1_prod);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prod <= r1_prod;
            r2_lz   <= n2_lz;
            r2_exp  <= r1_exp - $signed({5'b00000, n2_lz});
            r2_sign <= r1_sign;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
            r2_zero <= (r1_prod == 48'd0);
        end
    end

    always_comb begin
        s3_st  = 1'b0;
        s3_rsh = 11'd0;
        if (r2_exp >= 11'sd1) begin
            s3_shl = $signed({5'b00000, r2_lz});
        end else begin
            s3_shl = $signed({5'b00000, r2_lz}) + r2_exp - 11'sd1;
        end
        if (s3_shl >= 11'sd0) begin
            s3_pn = r2_prod << s3_shl[5:0];
        end else begin
            s3_rsh = 11'(-s3_shl);
            if (s3_rsh >= 11'd48) begin
                s3_pn = 48'd0;
                s3_st = |r2_prod;
            end else begin
                s3_pn = r2_prod >> s3_rsh[5:0];
                s3_st = |(r2_prod & ~({48{1'b1}} << s3_rsh[5:0]));
            end
        end
        s3_st   = s3_st | (|s3_pn[22:0]);
        s3_g    = s3_pn[23];
        s3_mant = s3_pn[47:24];
        s3_eenc = (r2_exp >= 11'sd1) ? r2_exp[7:0] : 8'd0;
        s3_rnd  = {1'b0, s3_eenc, s3_mant[22:0]}
                + {31'd0, s3_g & (s3_st | s3_mant[0])};
        if (r2_nan) begin
            n_p = C_QNAN;
        end else if (r2_inf || (r2_exp >= 11'sd255)) begin
            n_p = {r2_sign, 8'hFF, 23'd0};
        end else if (r2_zero) begin
            n_p = {r2_sign, 31'd0};
        end else begin
            n_p = {r2_sign, s3_rnd[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/f2iq_fadd.sv =====
module f2iq_fadd
    import f2iq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);

    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] x, y;
    logic [7:0]  xe, ye, d;
    logic [23:0] xm, ym;
    logic [26:0] ym27, yv;
    logic        yst;
    logic [27:0] n_sum;

    logic [27:0] r_sum;
    logic [7:0]  r_exp;
    logic        r_sign, r_nan, r_inf, r_inf_sign;

    logic [5:0]  b_lz;
    logic [7:0]  b_lim, b_sh;
    logic [26:0] b_m;
    logic [8:0]  b_e;
    logic [7:0]  b_eenc;
    logic [31:0] b_rnd;
    logic [31:0] n_s;
    logic [31:0] r_s;

    assign a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
    assign b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
    assign a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
    assign b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);
    assign swap  = (i_a[30:0] < i_b[30:0]);
    assign x     = swap ? i_b : i_a;
    assign y     = swap ? i_a : i_b;
    assign xe    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    assign ye    = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    assign xm    = {|x[30:23], x[22:0]};
    assign ym    = {|y[30:23], y[22:0]};
    assign d     = xe - ye;
    assign ym27  = {ym, 3'b000};

    always_comb begin
        if (d >= 8'd27) begin
            yv  = 27'd0;
            yst = |ym;
        end else begin
            yv  = ym27 >> d[4:0];
            yst = |(ym27 & ~({27{1'b1}} << d[4:0]));
        end
        yv[0] = yv[0] | yst;
        if (x[31] != y[31]) begin
            n_sum = {1'b0, xm, 3'b000} - {1'b0, yv};
        end else begin
            n_sum = {1'b0, xm, 3'b000} + {1'b0, yv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= n_sum;
            r_exp      <= xe;
            r_sign     <= x[31];
            r_nan      <= a_nan | b_nan | (a_inf & b_inf & (i_a[31] != i_b[31]));
            r_inf      <= a_inf | b_inf;
            r_inf_sign <= a_inf ? i_a[31] : i_b[31];
        end
    end

    always_comb begin
        b_lz  = lzc48({r_sum[26:0], 21'd0});
        b_lim = r_exp - 8'd1;
        b_sh  = 8'd0;
        if (r_sum[27]) begin
            b_m = r_sum[27:1] | {26'd0, r_sum[0]};
            b_e = {1'b0, r_exp} + 9'd1;
        end else begin
            b_sh = ({2'b00, b_lz} < b_lim) ? {2'b00, b_lz} : b_lim;
            b_m  = r_sum[26:0] << b_sh;
            b_e  = {1'b0, r_exp} - {1'b0, b_sh};
        end
        b_eenc = b_m[26] ? b_e[7:0] : 8'd0;
        b_rnd  = {1'b0, b_eenc, b_m[25:3]}
               + {31'd0, b_m[2] & (b_m[1] | b_m[0] | b_m[3])};
        if (r_nan) begin
            n_s = C_QNAN;
        end else if (r_inf) begin
            n_s = {r_inf_sign, 8'hFF, 23'd0};
        end else if (r_sum == 28'd0) begin
            n_s = 32'd0;
        end else if (b_m[26] && (b_e >= 9'd255)) begin
            n_s = {r_sign, 8'hFF, 23'd0};
        end else begin
            n_s = {r_sign, b_rnd[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== src/f2iq_cvt.sv =====
module f2iq_cvt
    import f2iq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_f,
    input  logic signed [7:0] i_lo,
    input  logic signed [7:0] i_hi,
    output logic signed [7:0] o_q
);

    logic [7:0]        e, eu, sh;
    logic [23:0]       m, ip, tmp;
    logic              g, st, nan;
    logic [8:0]        mag;
    logic signed [9:0] val, lo10, hi10, q;
    logic signed [7:0] r_q;

    assign e    = i_f[30:23];
    assign m    = {|e, i_f[22:0]};
    assign eu   = (e == 8'd0) ? 8'd1 : e;
    assign nan  = (e == 8'hFF) && (i_f[22:0] != 23'd0);
    assign lo10 = $signed({{2{i_lo[7]}}, i_lo});
    assign hi10 = $signed({{2{i_hi[7]}}, i_hi});

    always_comb begin
        sh  = 8'd0;
        ip  = 24'd0;
        tmp = 24'd0;
        g   = 1'b0;
        st  = 1'b0;
        if (eu >= 8'd135) begin
            mag = 9'd256;
        end else begin
            sh = 8'd150 - eu;
            if (sh >= 8'd26) begin
                mag = 9'd0;
            end else begin
                ip  = m >> sh;
                tmp = m >> (sh - 8'd1);
                g   = tmp[0];
                st  = |(m & ~({24{1'b1}} << (sh - 8'd1)));
                mag = {1'b0, ip[7:0]} + {8'd0, g & (st | ip[0])};
            end
        end
        val = i_f[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        q   = (nan || (val < lo10)) ? lo10 : val;
        if (q > hi10) begin
            q = hi10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= q[7:0];
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/float_to_int8_quad_quantizer.sv =====
// Quantises a beat of four fp32 samples into four int8 codes, one per channel, as
// round(clamp(round(round(x * scale) + zero))), with round-to-nearest-even at every
// step, NaN mapped to the lower bound and the upper bound applied last. Each channel
// runs a six-stage pipeline (multiply, leading-zero count, product rounding, aligned
// add, sum normalisation and rounding, clamp and integer conversion), so one beat is
// taken every cycle while the output is not stalled; a stall with a result waiting on
// the output holds the whole pipeline. Configuration must only be written while no beat
// is in flight.
module float_to_int8_quad_quantizer
    import f2iq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_beat    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_beat   o_out_data
);

    logic [63:0]            r_chan [C_NUM_CHAN];
    logic signed [7:0]      r_clamp_min, r_clamp_max;
    logic [C_LATENCY-1:0]   r_vld, r_last;
    logic                   w_en;
    logic [31:0]            w_smp  [C_NUM_CHAN];
    logic [31:0]            w_prod [C_NUM_CHAN];
    logic [31:0]            w_sum  [C_NUM_CHAN];
    logic signed [7:0]      w_code [C_NUM_CHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < C_NUM_CHAN; c++) begin
                r_chan[c] <= C_CHAN_RESET;
            end
            r_clamp_min <= C_CLAMP_MIN_RESET;
            r_clamp_max <= C_CLAMP_MAX_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CHAN0:     r_chan[0] <= i_cfg_data;
                REG_CHAN1:     r_chan[1] <= i_cfg_data;
                REG_CHAN2:     r_chan[2] <= i_cfg_data;
                REG_CHAN3:     r_chan[3] <= i_cfg_data;
                REG_CLAMP_MIN: r_clamp_min <= i_cfg_data[7:0];
                REG_CLAMP_MAX: r_clamp_max <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_en       = ~r_vld[C_LATENCY-1] | ~i_out_stall;
    assign o_in_stall = ~w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[C_LATENCY-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last <= {r_last[C_LATENCY-2:0], i_in_data.last_in};
        end
    end

    assign w_smp[0] = i_in_data.sample0;
    assign w_smp[1] = i_in_data.sample1;
    assign w_smp[2] = i_in_data.sample2;
    assign w_smp[3] = i_in_data.sample3;

    for (genvar c = 0; c < C_NUM_CHAN; c++) begin : g_lane
        f2iq_fmul u_fmul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_smp[c]),
            .i_b   (r_chan[c][63:32]),
            .o_p   (w_prod[c])
        );
        f2iq_fadd u_fadd (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_prod[c]),
            .i_b   (r_chan[c][31:0]),
            .o_s   (w_sum[c])
        );
        f2iq_cvt u_cvt (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_f   (w_sum[c]),
            .i_lo  (r_clamp_min),
            .i_hi  (r_clamp_max),
            .o_q   (w_code[c])
        );
    end

    assign o_out_valid         = r_vld[C_LATENCY-1];
    assign o_out_data.code0    = w_code[0];
    assign o_out_data.code1    = w_code[1];
    assign o_out_data.code2    = w_code[2];
    assign o_out_data.code3    = w_code[3];
    assign o_out_data.last_out = r_last[C_LATENCY-1];

endmodule

// ===== tb/tb_float_to_int8_quad_quantizer.sv =====
module tb_float_to_int8_quad_quantizer
    import f2iq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_PHASES    = 7;
    localparam int unsigned PHASE_BEATS = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;

    float_to_int8_quad_quantizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    logic [63:0]       chan_cfg [C_NUM_CHAN];
    logic signed [7:0] lo_bound;
    logic signed [7:0] hi_bound;

    t_in_beat  quads_to_send [$];
    t_out_beat codes_due [$];

    int unsigned cycle_cnt;
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned nan_quads;
    int unsigned send_wait;
    int unsigned stall_wait;
    bit          send_burst;
    bit          stall_burst;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Exact widening of a single-precision pattern to a real.
    function automatic real sp_to_real(input logic [31:0] f);
        logic [7:0]  e;
        logic [23:0] m;
        int          ex;
        e = f[30:23];
        m = {1'b0, f[22:0]};
        if (e == 8'hFF) begin
            if (f[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
            return $bitstoreal({f[31], 11'h7FF, 52'h0});
        end
        if (e == 0) begin
            if (m == 0) return $bitstoreal({f[31], 63'h0});
            ex = -126;
            while (!m[23]) begin
                m = m << 1;
                ex--;
            end
            return $bitstoreal({f[31], 11'(ex + 1023), m[22:0], 29'h0});
        end
        return $bitstoreal({f[31], 11'(int'(e) - 127 + 1023), f[22:0], 29'h0});
    endfunction

    // Round a real to single precision, nearest even, with gradual underflow.
    function automatic logic [31:0] real_to_sp(input real r);
        logic [63:0] b;
        logic [52:0] mant;
        logic [24:0] kept;
        logic [63:0] q;
        logic [63:0] below;
        int          ex;
        int          drop;
        bit          half;
        bit          sticky;
        b    = $realtobits(r);
        mant = {1'b1, b[51:0]};
        if (b[62:52] == 11'h7FF) begin
            if (b[51:0] != 0) return C_QNAN;
            return {b[63], 8'hFF, 23'h0};
        end
        if (b[62:52] == 0) return {b[63], 31'h0};
        ex = int'(b[62:52]) - 1023;
        if (ex > 127) return {b[63], 8'hFF, 23'h0};
        if (ex >= -126) begin
            kept   = {1'b0, mant[52:29]};
            half   = mant[28];
            sticky = |mant[27:0];
            if (half && (sticky || kept[0])) kept = kept + 1;
            if (kept[24]) begin
                kept = kept >> 1;
                ex++;
            end
            if (ex > 127) return {b[63], 8'hFF, 23'h0};
            return {b[63], 8'(ex + 127), kept[22:0]};
        end
        drop = 29 + (-126 - ex);
        if (drop > 54) return {b[63], 31'h0};
        q      = 64'(mant) >> drop;
        half   = mant[drop - 1];
        below  = (64'd1 << (drop - 1)) - 1;
        sticky = (64'(mant) & below) != 0;
        if (half && (sticky || q[0])) q = q + 1;
        return {b[63], q[30:0]};
    endfunction

    function automatic bit real_is_nan(input real r);
        logic [63:0] b;
        b = $realtobits(r);
        return b[62:52] == 11'h7FF && b[51:0] != 0;
    endfunction

    function automatic logic [7:0] quantise_lane(input logic [31:0] smp, input logic [63:0] cfg);
        real x;
        real prod;
        real sum;
        real lo;
        real hi;
        real a;
        real fr;
        int  t;
        x    = sp_to_real(smp);
        prod = sp_to_real(real_to_sp(x * sp_to_real(cfg[63:32])));
        sum  = sp_to_real(real_to_sp(prod + sp_to_real(cfg[31:0])));
        lo   = real'(int'(lo_bound));
        hi   = real'(int'(hi_bound));
        if (real_is_nan(sum)) a = lo;
        else a = (sum > lo) ? sum : lo;
        a  = (a < hi) ? a : hi;
        t  = $rtoi(a);
        fr = a - real'(t);
        if (fr > 0.5) t++;
        else if (fr < -0.5) t--;
        else if (fr == 0.5 && t[0]) t++;
        else if (fr == -0.5 && t[0]) t--;
        return t[7:0];
    endfunction

    function automatic t_out_beat quantise_quad(input t_in_beat q);
        t_out_beat r;
        r.code0    = quantise_lane(q.sample0, chan_cfg[0]);
        r.code1    = quantise_lane(q.sample1, chan_cfg[1]);
        r.code2    = quantise_lane(q.sample2, chan_cfg[2]);
        r.code3    = quantise_lane(q.sample3, chan_cfg[3]);
        r.last_out = q.last_in;
        return r;
    endfunction

    function automatic logic [31:0] random_sample();
        logic [31:0] f;
        case ($urandom_range(0, 9))
            0, 1: f = $urandom();
            2: f = {1'($urandom()), 8'($urandom_range(100, 160)), 23'($urandom())};
            3: begin
                case ($urandom_range(0, 5))
                    0: f = 32'h7F80_0000;
                    1: f = 32'hFF80_0000;
                    2: f = {1'($urandom()), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
                    3: f = {1'($urandom()), 8'h00, 23'($urandom())};
                    4: f = {1'($urandom()), 31'h0};
                    default: f = {1'($urandom()), 8'hFE, 23'($urandom())};
                endcase
            end
            4, 5: f = real_to_sp(real'($urandom_range(0, 700)) * 0.5 - 175.0);
            default: f = real_to_sp((real'($urandom_range(0, 200000)) - 100000.0) / 512.0);
        endcase
        return f;
    endfunction

    function automatic logic [63:0] random_chan_cfg();
        logic [31:0] scale;
        logic [31:0] zp;
        case ($urandom_range(0, 7))
            0: scale = 32'h3F80_0000;
            1: scale = {1'($urandom()), 8'($urandom_range(118, 134)), 23'($urandom())};
            2: scale = $urandom();
            3: scale = {1'($urandom()), 8'h00, 23'($urandom())};
            4: scale = {1'($urandom()), 31'h0};
            5: scale = ($urandom_range(0, 1)) ? C_QNAN : {1'($urandom()), 8'hFF, 23'h0};
            default: scale = real_to_sp(real'($urandom_range(1, 64)) * 0.25);
        endcase
        case ($urandom_range(0, 5))
            0: zp = '0;
            1: zp = $urandom();
            2: zp = {1'($urandom()), 8'hFF, 23'($urandom_range(0, 3))};
            default: zp = real_to_sp(real'($urandom_range(0, 80)) * 0.5 - 20.0);
        endcase
        return {scale, zp};
    endfunction

    // Driver: one beat in flight on the input, random per-beat gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait  <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                codes_due.push_back(quantise_quad(i_in_data));
                beats_sent <= beats_sent + 1;
            end
            if (send_wait > 0) begin
                send_wait  <= send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (quads_to_send.size() > 0) begin
                i_in_data  <= quads_to_send.pop_front();
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 15) == 0) send_burst <= ~send_burst;
                send_wait  <= send_burst ? 0 : $urandom_range(0, 9);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every accepted beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        bit        bad;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_wait  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (codes_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Unexpected beat %p at cycle %0d", o_out_data, cycle_cnt);
                end else begin
                    want = codes_due.pop_front();
                    bad  = (o_out_data.code0 !== want.code0) || (o_out_data.code1 !== want.code1)
                        || (o_out_data.code2 !== want.code2) || (o_out_data.code3 !== want.code3)
                        || (o_out_data.last_out !== want.last_out);
                    if (bad) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("Mismatch at beat %0d: expected %p, got %p",
                                     beats_checked, want, o_out_data);
                    end
                    beats_checked <= beats_checked + 1;
                end
                if ($urandom_range(0, 15) == 0) stall_burst <= ~stall_burst;
                stall_wait <= stall_burst ? 0 : $urandom_range(0, 9);
            end
            if (stall_wait > 0) begin
                i_out_stall <= 1'b1;
                if (!(o_out_valid && !i_out_stall)) stall_wait <= stall_wait - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_CLAMP_MIN: lo_bound = val[7:0];
            REG_CLAMP_MAX: hi_bound = val[7:0];
            default: chan_cfg[idx] = val;
        endcase
    endtask

    task automatic queue_quad(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d, input bit last);
        t_in_beat q;
        q.sample0 = a;
        q.sample1 = b;
        q.sample2 = c;
        q.sample3 = d;
        q.last_in = last;
        if (q.sample0[30:23] == 8'hFF || q.sample1[30:23] == 8'hFF
            || q.sample2[30:23] == 8'hFF || q.sample3[30:23] == 8'hFF) nan_quads++;
        quads_to_send.push_back(q);
    endtask

    task automatic wait_drained();
        while (quads_to_send.size() > 0 || i_in_valid || codes_due.size() > 0)
            @(posedge i_clk);
        repeat (C_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic queue_directed();
        queue_quad(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 1'b0);
        queue_quad(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 1'b1);
        queue_quad(C_QNAN, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001, 1'b0);
        queue_quad(32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h3F00_0000, 1'b0);
        queue_quad(32'hBF00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, 1'b1);
        queue_quad(32'h42FF_0000, 32'hC301_0000, 32'h42FD_0000, 32'h42FE_0000, 1'b0);
        queue_quad(32'h4300_0000, 32'hC300_0000, 32'h4F00_0000, 32'hCF00_0000, 1'b0);
        queue_quad(32'h3EFF_FFFF, 32'h3F00_0001, 32'hBF40_0000, 32'h4040_0000, 1'b1);
        queue_quad(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        queue_quad(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    endtask

    initial begin
        logic signed [7:0] lo;
        logic signed [7:0] hi;
        for (int c = 0; c < C_NUM_CHAN; c++) chan_cfg[c] = C_CHAN_RESET;
        lo_bound = C_CLAMP_MIN_RESET;
        hi_bound = C_CLAMP_MAX_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        wait_drained();

        // Crossed bounds, and channels that produce NaN, infinity and sub-unit scaling.
        write_reg(REG_CLAMP_MIN, 64'sd100);
        write_reg(REG_CLAMP_MAX, -64'sd100);
        write_reg(REG_CHAN0, {C_QNAN, 32'h0});
        write_reg(REG_CHAN1, {32'h0000_0000, 32'h7F80_0000});
        write_reg(REG_CHAN2, {32'h3E80_0000, 32'h3F00_0000});
        write_reg(REG_CHAN3, {32'hC000_0000, 32'hBF80_0000});
        queue_directed();
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin lo = -8'sd128; hi = 8'sd127; end
                1: begin lo = 8'sd0;    hi = 8'sd0;   end
                2: begin lo = 8'sd127;  hi = -8'sd128; end
                3: begin lo = -8'sd128; hi = -8'sd128; end
                4: begin lo = 8'sd127;  hi = 8'sd127;  end
                default: begin
                    lo = 8'($urandom_range(0, 255));
                    hi = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0 && lo > hi) {lo, hi} = {hi, lo};
                end
            endcase
            write_reg(REG_CLAMP_MIN, {{56{lo[7]}}, lo});
            write_reg(REG_CLAMP_MAX, {{56{hi[7]}}, hi});
            for (int c = 0; c < C_NUM_CHAN; c++)
                write_reg(t_reg_idx'(c), (p == 0) ? C_CHAN_RESET : random_chan_cfg());
            for (int i = 0; i < PHASE_BEATS; i++)
                queue_quad(random_sample(), random_sample(), random_sample(), random_sample(),
                           1'($urandom()));
            wait_drained();
        end

        $display("Sent %0d and checked %0d quads over %0d configuration phases (%0d with %s",
                 beats_sent, beats_checked, N_PHASES + 2, nan_quads, "non-finite samples),");
        $display("including crossed and collapsed clamp bounds and random gaps and stalls.");
        if (mismatches == 0 && codes_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/f2iq_pkg.sv
src/f2iq_fmul.sv
src/f2iq_fadd.sv
src/f2iq_cvt.sv
src/float_to_int8_quad_quantizer.sv
tb/tb_float_to_int8_quad_quantizer.sv
